/* hdl/tkd_pkg.sv */
// tkd_pkg: shared types, constants and register codes of the touch key detector
// used by the channel interface, the controller, the datapath, the top level and the checker
// depends on nothing
`default_nettype none

package tkd_pkg;

  // field widths fixed by the item formats
  localparam int IN_COUNT_W  = 16;
  localparam int OUT_VALUE_W = 16;
  localparam int OFFSET_W    = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // defaults for the top-level parameters
  localparam int CAL_SAMPLES_DEF   = 10;
  localparam int TRIM_EACH_END_DEF = 2;
  localparam int SCAN_SAMPLES_DEF  = 6;
  localparam int SAMPLE_WIDTH_DEF  = 16;

  // register reset values
  localparam logic [OFFSET_W-1:0]   OFFSET_RESET    = 12'd100;
  localparam logic [IN_COUNT_W-1:0] TIMEOUT_RESET   = 16'd59999;
  localparam logic                  SCAN_ONCE_RESET = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ONCE        = 2'd2;

  // result kinds
  localparam logic KIND_CAL  = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  typedef struct packed {
    logic [IN_COUNT_W-1:0] sample_count;
    logic                  timed_out;
    logic                  recalibrate;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic [OUT_VALUE_W-1:0] window_value;
    logic [OUT_VALUE_W-1:0] threshold_value;
    logic                   touched;
    logic                   press_event;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;      // latch sample, apply recalibrate
    logic scan_step;   // fold sample into the scan window
    logic pos_load;    // insertion position from fill index
    logic ins_rd;      // read the entry below the insertion position
    logic ins_shift;   // move that entry up one place
    logic ins_put;     // write the sample at the insertion position
    logic cal_adv;     // advance fill index, arm the sum on the last one
    logic sum_rd;      // read the entry at the sum pointer
    logic sum_acc;     // add it to the sum
    logic div_step;    // quotient by reciprocal multiply
    logic cal_finish;  // set threshold and post the calibration result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic calibrated;
    logic cal_idx_zero;
    logic cal_last;
    logic pos_one;
    logic rd_gt;
    logic sum_last;
    logic win_last;
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/tkd_chan_if.sv */
// tkd_chan_if: valid/ready channel carrying one packed payload
// depends on tkd_pkg for the default payload type
`default_nettype none

interface tkd_chan_if
  import tkd_pkg::*;
#(
  parameter type payload_t = in_item_t
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* hdl/tkd_ram.sv */
// tkd_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
`default_nettype none

module tkd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/tkd_ctrl.sv */
// tkd_ctrl: sequencer for sample intake, insertion sort, trimmed sum and division
// depends on tkd_pkg for the command and status structs
`default_nettype none

module tkd_ctrl
  import tkd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_CAL_ADV,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.calibrated) begin
          // hold the last window sample until the result slot is free
          if (!(status.win_last && status.out_full)) begin
            cmd.scan_step = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cmd.pos_load = 1'b1;
          state_nxt    = status.cal_idx_zero ? ST_INS_PUT : ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        cmd.ins_rd = 1'b1;
        state_nxt  = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (status.rd_gt) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = status.pos_one ? ST_INS_PUT : ST_INS_RD;
        end else begin
          cmd.ins_put = 1'b1;
          state_nxt   = ST_CAL_ADV;
        end
      end
      ST_INS_PUT: begin
        cmd.ins_put = 1'b1;
        state_nxt   = ST_CAL_ADV;
      end
      ST_CAL_ADV: begin
        cmd.cal_adv = 1'b1;
        state_nxt   = status.cal_last ? ST_SUM_RD : ST_IDLE;
      end
      ST_SUM_RD: begin
        cmd.sum_rd = 1'b1;
        state_nxt  = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        state_nxt   = status.sum_last ? ST_DIV : ST_SUM_RD;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_full) begin
          cmd.cal_finish = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

`default_nettype wire

/* hdl/tkd_dp.sv */
// tkd_dp: registers, calibration store, scan window, divider and result register
// depends on tkd_pkg and tkd_ram
`default_nettype none

module tkd_dp
  import tkd_pkg::*;
#(
  parameter int CAL_SAMPLES   = CAL_SAMPLES_DEF,
  parameter int TRIM_EACH_END = TRIM_EACH_END_DEF,
  parameter int SCAN_SAMPLES  = SCAN_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 status,
  input  wire in_item_t              in_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_item
);

  // samples wider than the input field carry no extra bits
  localparam int SW   = (SAMPLE_WIDTH < IN_COUNT_W) ? SAMPLE_WIDTH : IN_COUNT_W;
  localparam int TRIM = (2 * TRIM_EACH_END >= CAL_SAMPLES) ? (CAL_SAMPLES - 1) / 2
                                                            : TRIM_EACH_END;
  localparam int LO   = TRIM;
  localparam int HI   = CAL_SAMPLES - TRIM;
  localparam int CNT  = HI - LO;
  localparam int CW   = $clog2(CAL_SAMPLES);
  localparam int WW   = (SCAN_SAMPLES > 1) ? $clog2(SCAN_SAMPLES) : 1;
  localparam int AW   = SW + $clog2(CNT);
  // reciprocal of CNT, exact for every sum below 2**AW
  localparam int     LG    = $clog2(CNT);
  localparam int     SH    = AW + LG;
  localparam int     MW    = AW + 2;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(CNT) - longint'(1))
                             / longint'(CNT);

  logic [OFFSET_W-1:0]   offset_r;
  logic [IN_COUNT_W-1:0] timeout_r;
  logic                  scan_once_r;

  logic [SW-1:0]          sample_r;
  logic [CW-1:0]          cal_idx_r;
  logic [CW-1:0]          pos_r;
  logic [CW-1:0]          ptr_r;
  logic [SW-1:0]          win_max_r;
  logic [WW-1:0]          win_idx_r;
  logic [OUT_VALUE_W-1:0] thr_r;
  logic                   calibrated_r;
  logic                   released_r;
  logic [AW-1:0]          acc_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  // ram
  logic          ram_we;
  logic [CW-1:0] ram_raddr;
  logic [SW-1:0] ram_wdata;
  logic [SW-1:0] ram_rdata;

  assign ram_we    = cmd.ins_shift | cmd.ins_put;
  assign ram_wdata = cmd.ins_shift ? ram_rdata : sample_r;
  assign ram_raddr = cmd.ins_rd ? (pos_r - CW'(1)) : ptr_r;

  tkd_ram #(
    .WIDTH (SW),
    .DEPTH (CAL_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // intake
  logic [IN_COUNT_W-1:0] sample_sel;
  assign sample_sel = in_item.timed_out ? timeout_r : in_item.sample_count;

  // scan window
  logic [SW-1:0] win_max_nxt;
  logic          touched_nxt;
  logic          press_nxt;
  assign win_max_nxt = (sample_r > win_max_r) ? sample_r : win_max_r;
  assign touched_nxt = (OUT_VALUE_W'(win_max_nxt) >= thr_r);
  assign press_nxt   = scan_once_r ? (released_r & touched_nxt) : touched_nxt;

  // trimmed sum over CNT by multiplying with the constant reciprocal
  logic [AW+MW-1:0] quot_prod;
  logic [SW-1:0]    quot;
  assign quot_prod = (AW+MW)'(acc_r) * (AW+MW)'(RECIP);
  assign quot      = quot_prod[SH +: SW];

  // threshold, saturating
  logic [SW-1:0]          mean;
  logic [OUT_VALUE_W:0]   thr_sum;
  logic [OUT_VALUE_W-1:0] thr_nxt;
  assign mean    = acc_r[SW-1:0];
  assign thr_sum = (OUT_VALUE_W+1)'(mean) + (OUT_VALUE_W+1)'(offset_r);
  assign thr_nxt = thr_sum[OUT_VALUE_W] ? {OUT_VALUE_W{1'b1}} : thr_sum[OUT_VALUE_W-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= OFFSET_RESET;
      timeout_r    <= TIMEOUT_RESET;
      scan_once_r  <= SCAN_ONCE_RESET;
      cal_idx_r    <= '0;
      win_max_r    <= '0;
      win_idx_r    <= '0;
      thr_r        <= '0;
      calibrated_r <= 1'b0;
      released_r   <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD_OFFSET: offset_r    <= cfg_data[OFFSET_W-1:0];
          CFG_TIMEOUT_COUNT:    timeout_r   <= cfg_data[IN_COUNT_W-1:0];
          CFG_SCAN_ONCE:        scan_once_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.accept && in_item.recalibrate) begin
        calibrated_r <= 1'b0;
        cal_idx_r    <= '0;
        win_max_r    <= '0;
        win_idx_r    <= '0;
      end
      if (cmd.scan_step) begin
        if (win_idx_r == WW'(SCAN_SAMPLES - 1)) begin
          win_max_r   <= '0;
          win_idx_r   <= '0;
          released_r  <= ~touched_nxt;
          out_valid_r <= 1'b1;
        end else begin
          win_max_r <= win_max_nxt;
          win_idx_r <= win_idx_r + WW'(1);
        end
      end
      if (cmd.cal_adv) begin
        if (cal_idx_r == CW'(CAL_SAMPLES - 1)) begin
          cal_idx_r <= '0;
        end else begin
          cal_idx_r <= cal_idx_r + CW'(1);
        end
      end
      if (cmd.cal_finish) begin
        thr_r        <= thr_nxt;
        calibrated_r <= 1'b1;
        out_valid_r  <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= sample_sel[SW-1:0];
    end
    if (cmd.pos_load) begin
      pos_r <= cal_idx_r;
    end else if (cmd.ins_shift) begin
      pos_r <= pos_r - CW'(1);
    end
    if (cmd.cal_adv) begin
      ptr_r <= CW'(LO);
      acc_r <= '0;
    end
    if (cmd.sum_acc) begin
      acc_r <= acc_r + AW'(ram_rdata);
      ptr_r <= ptr_r + CW'(1);
    end
    if (cmd.div_step) begin
      acc_r <= AW'(quot);
    end
    if (cmd.scan_step && (win_idx_r == WW'(SCAN_SAMPLES - 1))) begin
      out_item_r.result_kind     <= KIND_SCAN;
      out_item_r.window_value    <= OUT_VALUE_W'(win_max_nxt);
      out_item_r.threshold_value <= thr_r;
      out_item_r.touched         <= touched_nxt;
      out_item_r.press_event     <= press_nxt;
    end
    if (cmd.cal_finish) begin
      out_item_r.result_kind     <= KIND_CAL;
      out_item_r.window_value    <= OUT_VALUE_W'(mean);
      out_item_r.threshold_value <= thr_nxt;
      out_item_r.touched         <= 1'b0;
      out_item_r.press_event     <= 1'b0;
    end
  end

  assign status.calibrated   = calibrated_r;
  assign status.cal_idx_zero = (cal_idx_r == '0);
  assign status.cal_last     = (cal_idx_r == CW'(CAL_SAMPLES - 1));
  assign status.pos_one      = (pos_r == CW'(1));
  assign status.rd_gt        = (ram_rdata > sample_r);
  assign status.sum_last     = (ptr_r == CW'(HI - 1));
  assign status.win_last     = (win_idx_r == WW'(SCAN_SAMPLES - 1));
  assign status.out_full     = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

/* hdl/touch_key_charge_time_detector.sv */
// touch_key_charge_time_detector: top level of the capacitive touch key detector
// depends on tkd_pkg, tkd_chan_if, tkd_ctrl and tkd_dp (which holds tkd_ram)
`default_nettype none

// One transfer on in_chan is one measured pad charge time; a timed-out
// measurement counts as timeout_count. After reset, or on an item with
// recalibrate set (that item being the first sample), the block gathers
// CAL_SAMPLES samples, keeps them sorted in a small RAM by insertion as they
// arrive, sums the middle ones (TRIM_EACH_END dropped at each end) and divides
// by multiplying with the constant reciprocal of their count; baseline plus
// threshold_offset, saturated at 65535, becomes the touch threshold, and one
// calibration result is sent. After that every SCAN_SAMPLES samples give one
// scan result with the window maximum, touched (maximum at or above threshold)
// and press_event (new touch only when scan_once is 1, every touched window
// when 0).
// Items are taken one at a time. A scan item is accepted and folded into the
// window. A calibration item is accepted, each stored sample larger than it is
// read, compared and moved up a place, then the item is written (at the bottom
// of the store, when empty or all larger, with no last compare) and the fill
// index advances. The item that completes calibration then reads and adds each
// middle entry, does the reciprocal multiply and posts the result. The result
// register lets the next item in while a result waits on out_chan; only an
// item that would produce a second result waits for it. Registers on the cfg
// port are to be written only while the block is idle, which it does not
// enforce; they take effect for the next item.

module touch_key_charge_time_detector
  import tkd_pkg::*;
#(
  parameter int CAL_SAMPLES   = CAL_SAMPLES_DEF,
  parameter int TRIM_EACH_END = TRIM_EACH_END_DEF,
  parameter int SCAN_SAMPLES  = SCAN_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tkd_chan_if.sink                   in_chan,
  tkd_chan_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  in_item_t   in_item;
  out_item_t  out_item;

  assign in_item = in_chan.payload;

  // sequencer: takes the input transfer and steps the datapath
  tkd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: config registers, sorted store, window, divider, result register
  tkd_dp #(
    .CAL_SAMPLES   (CAL_SAMPLES),
    .TRIM_EACH_END (TRIM_EACH_END),
    .SCAN_SAMPLES  (SCAN_SAMPLES),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_item  (out_item)
  );

  // result transfer payload straight from the result register
  assign out_chan.payload = out_item;

endmodule

`default_nettype wire

/* hdl/tkd_checker.sv */
// tkd_checker: port-level assertions for the touch key detector, bound to the top level
// depends on tkd_pkg and touch_key_charge_time_detector
`default_nettype none

module tkd_checker
  import tkd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  // one item at a time: ready drops after every input transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in the cycle after a transfer");

  // a posted result waits until it is taken
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped or changed before transfer");

  // calibration results carry no touch or press
  a_cal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.result_kind == KIND_CAL) |->
      !out_item.touched && !out_item.press_event)
    else $error("calibration result flags a touch");

  // a press only comes from a touched scan window
  a_press_touched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.press_event |->
      out_item.touched && (out_item.result_kind == KIND_SCAN))
    else $error("press without touch");

  // touched agrees with the reported maximum and threshold
  a_touch_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.result_kind == KIND_SCAN) |->
      (out_item.touched == (out_item.window_value >= out_item.threshold_value)))
    else $error("touched disagrees with window maximum and threshold");

endmodule

bind touch_key_charge_time_detector tkd_checker u_tkd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_item  (out_chan.payload)
);

`default_nettype wire

/* tb/tkd_charge_checker.sv */
// tkd_charge_checker: predicts the touch key detector's results from the observed
// transfers and register writes, and compares them with what the block sends
// depends on tkd_pkg
`timescale 1ns / 100ps

module tkd_charge_checker
  import tkd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_due,
  output int                    cal_seen,
  output int                    windows_seen,
  output int                    presses_seen
);

  localparam int CAL_N  = CAL_SAMPLES_DEF;
  localparam int TRIM_N = TRIM_EACH_END_DEF;
  localparam int SCAN_N = SCAN_SAMPLES_DEF;

  // register copies
  logic [OFFSET_W-1:0]   offset_r;
  logic [IN_COUNT_W-1:0] timeout_r;
  logic                  once_r;

  // detector state
  logic [15:0] cal_store [CAL_N];
  int          cal_fill;
  logic [15:0] win_max;
  int          win_fill;
  logic [15:0] threshold;
  logic        calibrated;
  logic        released;

  out_item_t due_results [$];
  int        fails;
  int        n_cal;
  int        n_win;
  int        n_press;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  // sorted copy of the store, ends trimmed, truncating mean of the rest
  function automatic logic [15:0] trimmed_baseline();
    logic [15:0] srt [CAL_N];
    logic [15:0] v;
    logic [31:0] acc;
    int          j;
    int          trim;
    for (int i = 0; i < CAL_N; i++) srt[i] = cal_store[i];
    for (int i = 1; i < CAL_N; i++) begin
      v = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    trim = (2 * TRIM_N >= CAL_N) ? (CAL_N - 1) / 2 : TRIM_N;
    acc = '0;
    for (int i = trim; i < CAL_N - trim; i++) acc += srt[i];
    return 16'(acc / (CAL_N - 2 * trim));
  endfunction

  task automatic fold_sample(input in_item_t it);
    logic [15:0] s;
    logic [15:0] mean;
    logic [16:0] sum;
    logic        hit;
    out_item_t   r;
    s = it.timed_out ? timeout_r : it.sample_count;
    if (it.recalibrate) begin
      calibrated = 1'b0;
      cal_fill   = 0;
      win_max    = '0;
      win_fill   = 0;
    end
    if (!calibrated) begin
      if (cal_fill >= CAL_N) cal_fill = 0;
      cal_store[cal_fill] = s;
      cal_fill++;
      if (cal_fill == CAL_N) begin
        cal_fill   = 0;
        mean       = trimmed_baseline();
        sum        = {1'b0, mean} + {5'b0, offset_r};
        threshold  = sum[16] ? 16'hFFFF : sum[15:0];
        calibrated = 1'b1;
        r.result_kind     = KIND_CAL;
        r.window_value    = mean;
        r.threshold_value = threshold;
        r.touched         = 1'b0;
        r.press_event     = 1'b0;
        due_results.push_back(r);
      end
    end else begin
      if (s > win_max) win_max = s;
      win_fill++;
      if (win_fill == SCAN_N) begin
        hit = (win_max >= threshold);
        r.result_kind     = KIND_SCAN;
        r.window_value    = win_max;
        r.threshold_value = threshold;
        r.touched         = hit;
        r.press_event     = once_r ? (released && hit) : hit;
        released = !hit;
        due_results.push_back(r);
        win_max  = '0;
        win_fill = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      offset_r   = OFFSET_RESET;
      timeout_r  = TIMEOUT_RESET;
      once_r     = SCAN_ONCE_RESET;
      cal_fill   = 0;
      win_max    = '0;
      win_fill   = 0;
      threshold  = '0;
      calibrated = 1'b0;
      released   = 1'b1;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD_OFFSET: offset_r  = cfg_data[OFFSET_W-1:0];
          CFG_TIMEOUT_COUNT:    timeout_r = cfg_data[IN_COUNT_W-1:0];
          CFG_SCAN_ONCE:        once_r    = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result transfer with nothing due");
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", out_item.result_kind, want.result_kind);
          check_field("window_value", out_item.window_value, want.window_value);
          check_field("threshold_value", out_item.threshold_value, want.threshold_value);
          check_field("touched", out_item.touched, want.touched);
          check_field("press_event", out_item.press_event, want.press_event);
        end
        if (out_item.result_kind == KIND_CAL) n_cal++;
        else n_win++;
        if (out_item.press_event) n_press++;
      end
      if (in_valid && in_ready) fold_sample(in_item);
    end
    fail_count   <= fails;
    results_due  <= due_results.size();
    cal_seen     <= n_cal;
    windows_seen <= n_win;
    presses_seen <= n_press;
  end

endmodule

/* tb/tb_touch_key_charge_time_detector.sv */
// tb_touch_key_charge_time_detector: stimulus and verdict for the touch key detector
// depends on tkd_pkg, tkd_chan_if, the detector top level and tkd_charge_checker
`timescale 1ns / 100ps

module tb_touch_key_charge_time_detector;
  import tkd_pkg::*;

  localparam int CAL_N         = CAL_SAMPLES_DEF;
  localparam int SCAN_N        = SCAN_SAMPLES_DEF;
  // calibration finish is the slowest step
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 300;
  localparam int WATCHDOG_NS   = 4_000_000;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tkd_chan_if #(.payload_t(in_item_t))  in_if ();
  tkd_chan_if #(.payload_t(out_item_t)) out_if ();

  int fail_count;
  int results_due;
  int cal_seen;
  int windows_seen;
  int presses_seen;

  // stimulus bookkeeping
  int          items_sent    = 0;
  int          settings_used = 1;   // reset values count as the first
  int          cur_offset    = OFFSET_RESET;
  bit          quiet         = 1'b0;  // no idling on either side while set
  bit          hold_req      = 1'b0;  // asks the receiver for one long hold-off

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  touch_key_charge_time_detector i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  tkd_charge_checker i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_item     (in_if.payload),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_item    (out_if.payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due),
    .cal_seen    (cal_seen),
    .windows_seen(windows_seen),
    .presses_seen(presses_seen)
  );

  // idle length: mostly none or short, now and then long
  function automatic int gap_cycles();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] sat16(input int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  // pad baseline for one calibration run: near the top now and then, so that
  // a large offset saturates the threshold, near zero sometimes
  function automatic int pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 65535 - int'($urandom_range(0, 3000));
    if (r < 3) return $urandom_range(0, 100);
    return $urandom_range(200, 60000);
  endfunction

  // one input transfer, with a random gap in front of it
  task automatic send_sample(input logic [15:0] cnt, input logic to, input logic rc);
    in_item_t it;
    int       gap;
    it.sample_count = cnt;
    it.timed_out    = to;
    it.recalibrate  = rc;
    gap = gap_cycles();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    items_sent++;
  endtask

  // sender stops until every predicted result has been transferred
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // new register setting, written only once the block has gone idle; an item
  // with no result may still be in flight, hence the settling pause
  task automatic next_setting(input logic [OFFSET_W-1:0] off,
                              input logic [IN_COUNT_W-1:0] tmo, input logic once);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESHOLD_OFFSET;
    cfg_data  <= CFG_DATA_W'(off);
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_COUNT;
    cfg_data  <= CFG_DATA_W'(tmo);
    @(posedge clk);
    cfg_index <= CFG_SCAN_ONCE;
    cfg_data  <= CFG_DATA_W'(once);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_offset = off;
    settings_used++;
  endtask

  // random phase: mostly calibration runs followed by scan windows, some of
  // them touched, with noise items and stray recalibrate requests mixed in
  task automatic run_phase(input int n, input bit stress);
    int   base;
    int   jitter;
    int   thr_guess;
    int   cal_left;
    int   scan_pos;
    int   r;
    int   v;
    bit   hot_win;
    logic to;
    base      = pick_level();
    jitter    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
    thr_guess = sat16(base + cur_offset);
    hot_win   = 1'b0;
    send_sample(sat16(base), 1'b0, 1'b1);
    cal_left = CAL_N - 1;
    scan_pos = 0;
    for (int k = 1; k < n; k++) begin
      // receiver holds off while the sender keeps offering, block fills up
      if (stress && k == 40) hold_req = 1'b1;
      // sender pauses mid-phase until every result is out
      if (stress && k == 120) drain_results();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_sample(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 15) == 0);
        if (cal_left > 0) cal_left--;
        else scan_pos = (scan_pos + 1) % SCAN_N;
      end else if (r < 10) begin
        // fresh calibration on a new level
        base      = pick_level();
        jitter    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        thr_guess = sat16(base + cur_offset);
        send_sample(sat16(base), 1'b0, 1'b1);
        cal_left = CAL_N - 1;
        scan_pos = 0;
      end else if (cal_left > 0) begin
        v  = base + int'($urandom_range(0, 2 * jitter)) - jitter;
        to = ($urandom_range(0, 24) == 0);
        send_sample(sat16(v), to, 1'b0);
        cal_left--;
      end else begin
        if (scan_pos == 0) hot_win = $urandom_range(0, 1);
        if (hot_win && $urandom_range(0, 2) == 0) begin
          // just below, exactly at and above the expected threshold
          case ($urandom_range(0, 2))
            0:       v = thr_guess - 1;
            1:       v = thr_guess;
            default: v = thr_guess + int'($urandom_range(0, 300));
          endcase
        end else begin
          v = base - int'($urandom_range(0, 2 * jitter + 20));
        end
        to = ($urandom_range(0, 29) == 0);
        send_sample(sat16(v), to, 1'b0);
        scan_pos = (scan_pos + 1) % SCAN_N;
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off counted here on request
  initial begin : out_ready_gen
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = gap_cycles();
      end
    end
  end

  // hard stop if the run hangs
  initial begin
    #(WATCHDOG_NS);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values: calibration with the field extremes
    // and a timed-out sample; middle six are all 1000, threshold 1100
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(16'h1234, 1'b1, 1'b0);
    repeat (7) send_sample(16'd1000, 1'b0, 1'b0);
    // window touched exactly at the threshold: new touch, press
    send_sample(16'd900, 1'b0, 1'b0);
    send_sample(16'd1099, 1'b0, 1'b0);
    send_sample(16'd1100, 1'b0, 1'b0);
    send_sample(16'd500, 1'b0, 1'b0);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'd1000, 1'b0, 1'b0);
    // still touched, field-maximum sample plus a timed-out one: no second press in once mode
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(16'h0001, 1'b1, 1'b0);
    repeat (4) send_sample(16'd200, 1'b0, 1'b0);
    // recalibrate mid-window, then partial scan data thrown away
    send_sample(16'd300, 1'b0, 1'b0);
    send_sample(16'd1000, 1'b0, 1'b1);

    // register settings, extremes first
    next_setting(12'd0, 16'd0, 1'b0);
    run_phase(190, 1'b0);
    next_setting(12'hFFF, 16'hFFFF, 1'b1);
    run_phase(190, 1'b0);
    next_setting(12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)), 1'b0);
    run_phase(200, 1'b1);
    quiet = 1'b1;
    next_setting(12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)), 1'b1);
    run_phase(190, 1'b0);
    quiet = 1'b0;
    next_setting(12'hFFF, 16'd0, 1'b0);
    run_phase(190, 1'b0);
    next_setting(12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)));
    run_phase(190, 1'b0);

    // all stimulus out: wait for the last results, then a quiet tail
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d input transfers over %0d register settings", items_sent,
             settings_used);
    $display("saw %0d calibrations, %0d scan windows, %0d presses", cal_seen,
             windows_seen, presses_seen);
    if (fail_count == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
